// ===== rtl/qrs_pkg.sv =====
// qrs_pkg: shared widths, codes and transaction types of the quadratic root solver
// no dependencies; used by every module of the solver
`timescale 1ns / 1ps
package qrs_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // square root width, discriminant width, 2*|q| width, quotient width
   localparam int ROOT_W = DATA_WIDTH + 1;
   localparam int DISC_W = 2 * ROOT_W;
   localparam int SUM_W  = DATA_WIDTH + 2;
   localparam int QUO_W  = DATA_WIDTH + FRAC_BITS + 1;

   typedef enum logic [1:0] {
      STATUS_TWO_ROOTS = 2'd0,
      STATUS_NO_ROOTS  = 2'd1,
      STATUS_DEGEN     = 2'd2
   } status_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] coef_a;
      logic signed [DATA_WIDTH-1:0] coef_b;
      logic signed [DATA_WIDTH-1:0] coef_c;
   } req_type;

   typedef struct packed {
      status_type                   root_status;
      logic signed [DATA_WIDTH-1:0] root_near;
      logic signed [DATA_WIDTH-1:0] root_far;
   } rsp_type;

   // sign/magnitude view of the coefficients plus the negative discriminant flag
   typedef struct packed {
      logic                  disc_neg;
      logic                  neg_a;
      logic                  neg_b;
      logic                  neg_c;
      logic [DATA_WIDTH-1:0] mag_a;
      logic [DATA_WIDTH-1:0] mag_b;
      logic [DATA_WIDTH-1:0] mag_c;
   } front_type;

endpackage

// ===== rtl/qrs_front.sv =====
// qrs_front: sign/magnitude split, products and discriminant in three stages
// depends on qrs_pkg
`timescale 1ns / 1ps
module qrs_front (
   input  logic                           clock,
   input  logic                           enable,
   input  qrs_pkg::req_type               req_data,
   output logic [qrs_pkg::DISC_W-1:0]     disc,
   output qrs_pkg::front_type             front
);

   localparam int DW = qrs_pkg::DATA_WIDTH;
   localparam int PW = 2 * DW;

   logic [DW-1:0] ua, ub, uc;
   qrs_pkg::front_type a_in, a_ff;

   logic [PW-1:0] b2_in, b2_ff, ac_in, ac_ff;
   logic          addsub_in, addsub_ff;
   qrs_pkg::front_type b_ff;

   logic [qrs_pkg::DISC_W-1:0] ac4, b2w, disc_in, disc_ff;
   qrs_pkg::front_type c_in, c_ff;

   // stage a: magnitudes
   always_comb begin
      ua = req_data.coef_a;
      ub = req_data.coef_b;
      uc = req_data.coef_c;
      a_in          = '0;
      a_in.neg_a    = ua[DW-1];
      a_in.neg_b    = ub[DW-1];
      a_in.neg_c    = uc[DW-1];
      a_in.mag_a    = ua[DW-1] ? (~ua + 1'b1) : ua;
      a_in.mag_b    = ub[DW-1] ? (~ub + 1'b1) : ub;
      a_in.mag_c    = uc[DW-1] ? (~uc + 1'b1) : uc;
   end

   // stage b: products
   assign b2_in     = PW'(a_ff.mag_b) * PW'(a_ff.mag_b);
   assign ac_in     = PW'(a_ff.mag_a) * PW'(a_ff.mag_c);
   assign addsub_in = (a_ff.neg_a != a_ff.neg_c) && (a_ff.mag_a != '0) && (a_ff.mag_c != '0);

   // stage c: discriminant
   always_comb begin
      ac4           = {ac_ff, 2'b00};
      b2w           = qrs_pkg::DISC_W'(b2_ff);
      c_in          = b_ff;
      c_in.disc_neg = !addsub_ff && (ac4 > b2w);
      disc_in       = addsub_ff ? (b2w + ac4) : (b2w - ac4);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_ff      <= a_in;
         b2_ff     <= b2_in;
         ac_ff     <= ac_in;
         addsub_ff <= addsub_in;
         b_ff      <= a_ff;
         c_ff      <= c_in;
         disc_ff   <= disc_in;
      end
   end

   assign disc  = disc_ff;
   assign front = c_ff;

endmodule

// ===== rtl/qrs_sqrt.sv =====
// qrs_sqrt: pipelined floor square root, one root bit per stage
// depends on qrs_pkg for default widths
`timescale 1ns / 1ps
module qrs_sqrt #(
   parameter int ROOT_W = qrs_pkg::ROOT_W,
   parameter int SIDE_W = 8
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [2*ROOT_W-1:0]   radicand,
   input  logic [SIDE_W-1:0]     side_in,
   output logic [ROOT_W-1:0]     root,
   output logic [SIDE_W-1:0]     side_out
);

   localparam int RDW = 2 * ROOT_W;

   logic [RDW-1:0]    rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [SIDE_W-1:0] side_ff [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
      localparam int BIT = ROOT_W - 1 - j;
      logic [RDW-1:0]    rem_prev, trial, rem_in;
      logic [ROOT_W-1:0] root_prev, root_in;
      logic [SIDE_W-1:0] side_prev;
      logic              take;

      if (j == 0) begin : g_first
         assign rem_prev  = radicand;
         assign root_prev = '0;
         assign side_prev = side_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      // (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i)
      always_comb begin
         trial   = (RDW'(root_prev) << (BIT + 1)) | (RDW'(1) << (2 * BIT));
         take    = rem_prev >= trial;
         rem_in  = take ? (rem_prev - trial) : rem_prev;
         root_in = root_prev | (take ? (ROOT_W'(1) << BIT) : '0);
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign root     = root_ff[ROOT_W-1];
   assign side_out = side_ff[ROOT_W-1];

endmodule

// ===== rtl/qrs_div.sv =====
// qrs_div: pipelined restoring unsigned divider, one quotient bit per stage
// depends on qrs_pkg for default widths
`timescale 1ns / 1ps
module qrs_div #(
   parameter int QUO_W  = qrs_pkg::QUO_W,
   parameter int DIV_W  = qrs_pkg::SUM_W,
   parameter int SIDE_W = 1
) (
   input  logic                 clock,
   input  logic                 enable,
   input  logic [QUO_W-1:0]     dividend,
   input  logic [DIV_W-1:0]     divisor,
   input  logic [SIDE_W-1:0]    side_in,
   output logic [QUO_W-1:0]     quotient,
   output logic [SIDE_W-1:0]    side_out
);

   logic [QUO_W-1:0]  num_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [DIV_W-1:0]  rem_ff  [QUO_W];
   logic [DIV_W-1:0]  den_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_stage
      logic [QUO_W-1:0]  num_prev, quo_prev;
      logic [DIV_W-1:0]  rem_prev, den_prev, rem_in;
      logic [DIV_W:0]    rem_shift, diff;
      logic [SIDE_W-1:0] side_prev;
      logic              take;

      if (j == 0) begin : g_first
         assign num_prev  = dividend;
         assign quo_prev  = '0;
         assign rem_prev  = '0;
         assign den_prev  = divisor;
         assign side_prev = side_in;
      end else begin : g_next
         assign num_prev  = num_ff[j-1];
         assign quo_prev  = quo_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign den_prev  = den_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      always_comb begin
         rem_shift = {rem_prev, num_prev[QUO_W-1]};
         diff      = rem_shift - {1'b0, den_prev};
         take      = rem_shift >= {1'b0, den_prev};
         rem_in    = take ? diff[DIV_W-1:0] : rem_shift[DIV_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            num_ff[j]  <= {num_prev[QUO_W-2:0], 1'b0};
            quo_ff[j]  <= {quo_prev[QUO_W-2:0], take};
            rem_ff[j]  <= rem_in;
            den_ff[j]  <= den_prev;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign quotient = quo_ff[QUO_W-1];
   assign side_out = side_ff[QUO_W-1];

endmodule

// ===== rtl/quadratic_root_solver_core.sv =====
// quadratic_root_solver_core: top level of the fixed-point quadratic root solver
// depends on qrs_pkg, qrs_front, qrs_sqrt and qrs_div
`timescale 1ns / 1ps

// Solves a*t^2 + b*t + c = 0 for signed Q16.16 coefficients, one transaction per
// clock. Each transaction returns exactly one result: status two roots with the
// smaller root in root_near and the larger in root_far (each saturated to Q16.16,
// both truncated toward zero), status no roots when the discriminant is negative,
// or status degenerate when a or q is zero; both roots read zero unless two roots.
// The pipeline is fully streaming: a new transaction can enter every cycle. It
// runs through the front end, the bit-per-stage square root (33 stages), the
// prep stage, the bit-per-stage dividers (49 stages) and the output register.
// All stages advance together; when the output register holds a result that is
// not taken, the whole pipeline holds and req_ready drops.
module quadratic_root_solver_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  qrs_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output qrs_pkg::rsp_type  rsp_data
);

   localparam int DW     = qrs_pkg::DATA_WIDTH;
   localparam int FB     = qrs_pkg::FRAC_BITS;
   localparam int ROOT_W = qrs_pkg::ROOT_W;
   localparam int SUM_W  = qrs_pkg::SUM_W;
   localparam int QUO_W  = qrs_pkg::QUO_W;
   localparam int FR_W   = $bits(qrs_pkg::front_type);
   // front, square root, prep and divider stages ahead of the output register
   localparam int LAT    = 3 + ROOT_W + 1 + QUO_W;

   // global advance: pipeline moves when the output slot is free or drained
   logic enable;
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   // valid bits travel alongside the data
   logic [LAT-1:0] valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[LAT-2:0], req_valid};
      end
   end

   // discriminant front end
   logic [qrs_pkg::DISC_W-1:0] disc;
   qrs_pkg::front_type         front, front_sq;
   logic [FR_W-1:0]            front_bits;
   logic [ROOT_W-1:0]          root;

   qrs_front u_front (
      .clock    (clock),
      .enable   (enable),
      .req_data (req_data),
      .disc     (disc),
      .front    (front)
   );

   // floor square root, coefficient info riding along
   qrs_sqrt #(
      .ROOT_W (ROOT_W),
      .SIDE_W (FR_W)
   ) u_sqrt (
      .clock    (clock),
      .enable   (enable),
      .radicand (disc),
      .side_in  (front),
      .root     (root),
      .side_out (front_bits)
   );
   assign front_sq = front_bits;

   // prep stage: s = 2*|q|, status and root signs, divider operands
   logic [SUM_W-1:0]   sum;
   qrs_pkg::status_type status_in;
   logic               neg_q, neg0_in, neg1_in;

   qrs_pkg::status_type status_ff;
   logic               neg0_ff, neg1_ff;
   logic [QUO_W-1:0]   num0_ff, num1_ff;
   logic [SUM_W-1:0]   den0_ff, den1_ff;

   always_comb begin
      sum   = SUM_W'(front_sq.mag_b) + SUM_W'(root);
      neg_q = !front_sq.neg_b;
      if (front_sq.disc_neg) begin
         status_in = qrs_pkg::STATUS_NO_ROOTS;
      end else if ((front_sq.mag_a == '0) || (sum == '0)) begin
         status_in = qrs_pkg::STATUS_DEGEN;
      end else begin
         status_in = qrs_pkg::STATUS_TWO_ROOTS;
      end
      neg0_in = neg_q != front_sq.neg_a;
      neg1_in = (front_sq.neg_c != neg_q) && (front_sq.mag_c != '0);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         status_ff <= status_in;
         neg0_ff   <= neg0_in;
         neg1_ff   <= neg1_in;
         // q/a at frac scale: (s/2) << F over |a|
         num0_ff   <= QUO_W'(sum) << (FB - 1);
         den0_ff   <= SUM_W'(front_sq.mag_a);
         // c/q at frac scale: (c << F) over s/2
         num1_ff   <= QUO_W'(front_sq.mag_c) << (FB + 1);
         den1_ff   <= sum;
      end
   end

   // two dividers in lockstep; status and sign of t0 go with the first
   logic [QUO_W-1:0] quo0, quo1;
   logic [2:0]       side0;
   logic             neg1_out;

   qrs_div #(
      .QUO_W  (QUO_W),
      .DIV_W  (SUM_W),
      .SIDE_W (3)
   ) u_div_t0 (
      .clock    (clock),
      .enable   (enable),
      .dividend (num0_ff),
      .divisor  (den0_ff),
      .side_in  ({status_ff, neg0_ff}),
      .quotient (quo0),
      .side_out (side0)
   );

   qrs_div #(
      .QUO_W  (QUO_W),
      .DIV_W  (SUM_W),
      .SIDE_W (1)
   ) u_div_t1 (
      .clock    (clock),
      .enable   (enable),
      .dividend (num1_ff),
      .divisor  (den1_ff),
      .side_in  (neg1_ff),
      .quotient (quo1),
      .side_out (neg1_out)
   );

   // saturate from sign and magnitude to the signed data range
   function automatic logic signed [DW-1:0] sat_root(input logic neg, input logic [QUO_W-1:0] mag);
      logic             big;
      logic [DW-1:0]    low;
      logic signed [DW-1:0] res;
      big = |mag[QUO_W-1:DW-1];
      low = mag[DW-1:0];
      if (neg) begin
         res = big ? {1'b1, {(DW-1){1'b0}}} : (~low + 1'b1);
      end else begin
         res = big ? {1'b0, {(DW-1){1'b1}}} : low;
      end
      return res;
   endfunction

   // output stage: saturate, order, mask non-root statuses
   qrs_pkg::status_type  status_out;
   logic signed [DW-1:0] t0, t1;
   qrs_pkg::rsp_type     rsp_in, rsp_ff;
   logic                 rsp_valid_ff;

   always_comb begin
      status_out = qrs_pkg::status_type'(side0[2:1]);
      t0         = sat_root(side0[0], quo0);
      t1         = sat_root(neg1_out, quo1);
      rsp_in             = '0;
      rsp_in.root_status = status_out;
      if (status_out == qrs_pkg::STATUS_TWO_ROOTS) begin
         rsp_in.root_near = (t0 > t1) ? t1 : t0;
         rsp_in.root_far  = (t0 > t1) ? t0 : t1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= valid_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== tb/sv/tb_quadratic_root_solver_core.sv =====
// tb_quadratic_root_solver_core: self-checking bench for the fixed-point quadratic solver
// depends on qrs_pkg and quadratic_root_solver_core; random stimulus, predicted results
`timescale 1ns / 1ps

// expected-result store plus the exact-integer root predictor
class root_scoreboard;
   qrs_pkg::rsp_type expected_roots[$];
   int               mismatches;
   int               checked;
   int               status_seen[3];

   function new();
      mismatches = 0;
      checked    = 0;
   endfunction

   // floor square root of a value below 2^66
   static function logic [127:0] floor_sqrt(logic [127:0] v);
      logic [127:0] root;
      logic [127:0] cand;
      root = '0;
      for (int i = 40; i >= 0; i--) begin
         cand = root | (128'd1 << i);
         if (cand * cand <= v) root = cand;
      end
      return root;
   endfunction

   static function logic signed [31:0] clamp_root(logic neg, logic [127:0] mag);
      if (mag >= 128'h8000_0000) return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      return neg ? -$signed(mag[31:0]) : $signed(mag[31:0]);
   endfunction

   static function qrs_pkg::rsp_type solve_roots(qrs_pkg::req_type q);
      qrs_pkg::rsp_type res;
      logic             na, nb, nc, nq;
      logic [127:0]     ma, mb, mc, b2, ac4, disc, rt, s;
      logic signed [31:0] t0, t1, tmp;
      res = '0;
      res.root_status = qrs_pkg::STATUS_TWO_ROOTS;
      na = q.coef_a[31];
      nb = q.coef_b[31];
      nc = q.coef_c[31];
      ma = na ? 128'(-q.coef_a) & 128'hffff_ffff : 128'(q.coef_a) & 128'hffff_ffff;
      mb = nb ? 128'(-q.coef_b) & 128'hffff_ffff : 128'(q.coef_b) & 128'hffff_ffff;
      mc = nc ? 128'(-q.coef_c) & 128'hffff_ffff : 128'(q.coef_c) & 128'hffff_ffff;
      b2  = mb * mb;
      ac4 = (ma * mc) << 2;
      if (na != nc && ma != 0 && mc != 0) begin
         disc = b2 + ac4;
      end else begin
         if (ac4 > b2) begin
            res.root_status = qrs_pkg::STATUS_NO_ROOTS;
            return res;
         end
         disc = b2 - ac4;
      end
      rt = floor_sqrt(disc);
      s  = mb + rt;   // twice |q|
      nq = !nb;
      if (ma == 0 || s == 0) begin
         res.root_status = qrs_pkg::STATUS_DEGEN;
         return res;
      end
      t0 = clamp_root(nq != na, (s << 15) / ma);
      t1 = clamp_root(nc != nq && mc != 0, (mc << 17) / s);
      if (t0 > t1) begin
         tmp = t0;
         t0  = t1;
         t1  = tmp;
      end
      res.root_near = t0;
      res.root_far  = t1;
      return res;
   endfunction

   function void note_request(qrs_pkg::req_type q);
      expected_roots = {expected_roots, solve_roots(q)};
   endfunction

   function void check_response(qrs_pkg::rsp_type r);
      qrs_pkg::rsp_type e;
      if (expected_roots.size() == 0) begin
         $error("unexpected response status=%0d near=%0d far=%0d",
                r.root_status, r.root_near, r.root_far);
         mismatches++;
         return;
      end
      e = expected_roots.pop_front();
      checked++;
      if (e.root_status <= qrs_pkg::STATUS_DEGEN) status_seen[e.root_status]++;
      if (r.root_status !== e.root_status) begin
         $error("root_status expected %0d actual %0d", e.root_status, r.root_status);
         mismatches++;
      end
      if (r.root_near !== e.root_near) begin
         $error("root_near expected %0d actual %0d", e.root_near, r.root_near);
         mismatches++;
      end
      if (r.root_far !== e.root_far) begin
         $error("root_far expected %0d actual %0d", e.root_far, r.root_far);
         mismatches++;
      end
   endfunction

   function int pending();
      return expected_roots.size();
   endfunction
endclass

module tb_quadratic_root_solver_core;

   localparam int RANDOM_ITEMS = 1150;
   localparam int LONG_HOLD    = 300;   // well beyond the 87-stage pipeline depth
   localparam int DRAIN_CYCLES = 120;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   qrs_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   qrs_pkg::rsp_type rsp_data;

   root_scoreboard sb = new();
   logic           hold_output = 1'b0;   // sender asks the receiver for a long stall
   logic           run_done = 1'b0;
   int             sent = 0;

   quadratic_root_solver_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // offer one transaction and hold it until the handshake completes
   task automatic send_coefs(qrs_pkg::req_type q);
      int gap;
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
      sb.note_request(q);
      sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic qrs_pkg::req_type mk(int a, int b, int c);
      qrs_pkg::req_type q;
      q.coef_a = a;
      q.coef_b = b;
      q.coef_c = c;
      return q;
   endfunction

   // one random coefficient: full range, modest magnitude, or a special value
   function automatic logic [31:0] rand_coef();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35) return $urandom();
      if (roll < 75) return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
      if (roll < 85) return $urandom_range(0, 32'h0000_0fff) - 32'h0000_0800;
      case ($urandom_range(0, 4))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         3: return 32'h0001_0000;
         default: return 32'hffff_ffff;
      endcase
   endfunction

   // build a well-formed equation from two chosen roots: a(t-r0)(t-r1)
   function automatic qrs_pkg::req_type from_roots();
      longint a, r0, r1;
      qrs_pkg::req_type q;
      a  = longint'($urandom_range(1, 32'h0004_0000)) * ($urandom_range(0, 1) ? 1 : -1);
      r0 = longint'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      r1 = longint'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      q.coef_a = a[31:0];
      q.coef_b = 32'((-a * (r0 + r1)) >>> 16);
      q.coef_c = 32'(((a * r0 >>> 16) * r1) >>> 16);
      return q;
   endfunction

   // receiver: random stalls, plus one long hold on request
   initial begin
      int gap;
      @(negedge reset);
      while (!run_done) begin
         if (hold_output) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_output = 1'b0;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   // stimulus
   initial begin
      qrs_pkg::req_type q;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes and each special case
      send_coefs(mk(32'h0001_0000, 32'hfffe_0000, 32'h0001_0000));   // equal roots at 1.0
      send_coefs(mk(32'h0001_0000, 32'h0000_0000, 32'hffff_0000));   // roots -1, +1
      send_coefs(mk(32'h0001_0000, 32'h0000_0000, 32'h0001_0000));   // negative discriminant
      send_coefs(mk(32'h0000_0000, 32'h0002_0000, 32'h0001_0000));   // a zero
      send_coefs(mk(32'h0000_0000, 32'h0000_0000, 32'h0001_0000));   // a and b zero
      send_coefs(mk(32'h0001_0000, 32'h0000_0000, 32'h0000_0000));   // q zero
      send_coefs(mk(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
      send_coefs(mk(32'h0000_0001, 32'h7fff_ffff, 32'h0000_0001));   // saturating root
      send_coefs(mk(32'h0000_0001, 32'h8000_0000, 32'h8000_0000));
      send_coefs(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_coefs(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
      send_coefs(mk(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
      send_coefs(mk(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
      send_coefs(mk(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
      send_coefs(mk(32'h0000_0001, 32'h0000_0001, 32'h0000_0001));
      send_coefs(mk(32'hffff_0000, 32'h0003_0000, 32'hfffe_0000));   // negative a, roots 1, 2
      send_coefs(mk(32'h0000_0001, 32'h0000_0000, 32'h8000_0000));   // huge disc via a*c
      send_coefs(mk(32'h0000_8000, 32'hffff_8000, 32'h0000_0000));   // c zero

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 3) begin
            hold_output = 1'b1;   // receiver stalls, pipeline fills, input backs up
         end
         if (i == 2 * RANDOM_ITEMS / 3) begin
            // sender pause until all outstanding results are back
            req_valid <= 1'b0;
            do @(posedge clock); while (sb.pending() != 0);
         end
         if ($urandom_range(0, 99) < 55) q = from_roots();
         else q = mk(rand_coef(), rand_coef(), rand_coef());
         send_coefs(q);
      end
      req_valid <= 1'b0;

      // drain and settle
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      run_done = 1'b1;

      $display("covered %0d transactions, %0d results checked", sent, sb.checked);
      $display("status mix: two roots %0d, no roots %0d, degenerate %0d",
               sb.status_seen[0], sb.status_seen[1], sb.status_seen[2]);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("[quadratic_root_solver_core] OK");
      end else begin
         $display("[quadratic_root_solver_core] ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("[quadratic_root_solver_core] ERROR");
      $finish;
   end

endmodule
